@@ hdl/psp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_pkg
// Shared widths, latencies and register codes of the segment step planner.
// ----------------------------------------------------------------------------
package psp_pkg;

  localparam int CoordW   = 18;
  localparam int StepsW   = 19;
  localparam int DistW    = 19;
  localparam int TimeW    = 39;
  localparam int CfgW     = 16;

  localparam int DivW     = 39;
  localparam int DivisorW = 18;
  localparam int DivLat   = DivW;

  localparam int SqInW    = 38;
  localparam int SqLat    = DistW;
  localparam int SqRemW   = 21;

  localparam int UsPerS   = 1000000;
  localparam int UsW      = 20;

  localparam logic [CfgW-1:0] SpeedReset = 16'd100;
  localparam logic [CfgW-1:0] StepReset  = 16'd157;

  typedef enum logic {
    REG_SPEED = 1'b0,
    REG_STEP  = 1'b1
  } reg_idx_t;

endpackage

@@ hdl/plotter_segment_step_planner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plotter_segment_step_planner
// Step counts, length, duration and step periods of one plotter pen move.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one segment per transaction: start and end point in um.
//   m_* returns one plan per segment, in order: signed step counts and
//   direction per axis, floor of the length, duration and step periods.
//   The APB port holds pen speed (0x0) and step length (0x4); write them only
//   while no segment is in flight. A zero value acts as one.
// Timing:
//   One segment per cycle unless stalled. A segment passes the delta stage,
//   square and sum stages, a 19-stage root, a multiply stage, then two
//   39-stage dividers in series (length over speed, duration over step count)
//   and the output register; the step count dividers run beside the root.
// Reset clears all valid bits and loads the register reset values.
// Stall: when the output holds a plan that is not taken, the whole pipeline
//   freezes and s_tready drops; bubbles drain while the output is empty.
// ----------------------------------------------------------------------------
module plotter_segment_step_planner
  import psp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_x_um[17:0], start_y_um[35:18], end_x_um[53:36], end_y_um[71:54]
  input  logic [71:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // steps_x[18:0], steps_y[37:19], dir_x[38], dir_y[39], distance_um[58:40],
  // duration_us[97:59], period_x_us[136:98], period_y_us[175:137]
  output logic [175:0] m_tdata
);

  localparam int LatSide = 22;
  localparam int LatEnd  = 100;
  localparam int DistLn  = LatEnd - 21;

  logic [CfgW-1:0] speed;
  logic [CfgW-1:0] step_len;
  logic            en;
  reg_idx_t        widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      speed    <= SpeedReset;
      step_len <= StepReset;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_SPEED: speed    <= pwdata[CfgW-1:0];
        REG_STEP:  step_len <= pwdata[CfgW-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_SPEED: prdata = 32'(speed);
      REG_STEP:  prdata = 32'(step_len);
      default:   prdata = '0;
    endcase
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [DivisorW-1:0] speed_d;
  logic [DivisorW-1:0] slen_d;
  assign speed_d = (speed == '0) ? DivisorW'(1) : DivisorW'(speed);
  assign slen_d  = (step_len == '0) ? DivisorW'(1) : DivisorW'(step_len);

  // delta stage
  logic [CoordW-1:0] sx, sy, ex, ey;
  logic [CoordW-1:0] ax, ay;
  logic              nx, ny;
  assign sx = s_tdata[17:0];
  assign sy = s_tdata[35:18];
  assign ex = s_tdata[53:36];
  assign ey = s_tdata[71:54];

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= (ex >= sx) ? ex - sx : sx - ex;
      ay <= (ey >= sy) ? ey - sy : sy - ey;
      nx <= ex < sx;
      ny <= ey < sy;
    end
  end

  logic vld [0:LatEnd];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LatEnd; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i <= LatEnd; i++) vld[i] <= vld[i-1];
    end
  end

  // step counts
  logic [DivW-1:0] qx, qy;
  psp_div u_div_sx (.clk, .en, .dividend(DivW'(ax)), .divisor(slen_d), .quotient(qx));
  psp_div u_div_sy (.clk, .en, .dividend(DivW'(ay)), .divisor(slen_d), .quotient(qy));

  // length
  logic [2*CoordW-1:0] sqx, sqy;
  logic [SqInW-1:0]    sq_sum;
  logic [DistW-1:0]    dist_um;
  always_ff @(posedge clk) begin
    if (en) begin
      sqx    <= ax * ax;
      sqy    <= ay * ay;
      sq_sum <= SqInW'(sqx) + SqInW'(sqy);
    end
  end
  psp_sqrt u_sqrt (.clk, .en, .radicand(sq_sum), .root(dist_um));

  logic [TimeW-1:0] dur_num;
  always_ff @(posedge clk) begin
    if (en) dur_num <= TimeW'(dist_um) * TimeW'(UsPerS);
  end

  logic [DivW-1:0] dur;
  psp_div u_div_dur (.clk, .en, .dividend(dur_num), .divisor(speed_d), .quotient(dur));

  // side lines
  logic [1:0]          sgn_ln  [0:LatEnd-1];
  logic [DistW-1:0]    dist_ln [0:DistLn-1];
  logic [DivisorW-1:0] stx_ln  [0:LatSide+DivLat-1];
  logic [DivisorW-1:0] sty_ln  [0:LatSide+DivLat-1];
  logic [TimeW-1:0]    dur_ln  [0:DivLat-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sgn_ln[0]  <= {ny, nx};
      dist_ln[0] <= dist_um;
      stx_ln[0]  <= qx[DivisorW-1:0];
      sty_ln[0]  <= qy[DivisorW-1:0];
      dur_ln[0]  <= dur;
      for (int i = 1; i < LatEnd; i++) sgn_ln[i] <= sgn_ln[i-1];
      for (int i = 1; i < DistLn; i++) dist_ln[i] <= dist_ln[i-1];
      for (int i = 1; i < LatSide + DivLat; i++) begin
        stx_ln[i] <= stx_ln[i-1];
        sty_ln[i] <= sty_ln[i-1];
      end
      for (int i = 1; i < DivLat; i++) dur_ln[i] <= dur_ln[i-1];
    end
  end

  // periods
  logic [DivW-1:0] px, py;
  psp_div u_div_px (.clk, .en, .dividend(dur), .divisor(stx_ln[LatSide-1]), .quotient(px));
  psp_div u_div_py (.clk, .en, .dividend(dur), .divisor(sty_ln[LatSide-1]), .quotient(py));

  // output register
  logic [DivisorW-1:0] stx, sty;
  logic                negx, negy;
  assign stx  = stx_ln[LatSide+DivLat-1];
  assign sty  = sty_ln[LatSide+DivLat-1];
  assign negx = sgn_ln[LatEnd-1][0] && (stx != '0);
  assign negy = sgn_ln[LatEnd-1][1] && (sty != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld[LatEnd];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata[18:0]    <= negx ? StepsW'(-StepsW'(stx)) : StepsW'(stx);
      m_tdata[37:19]   <= negy ? StepsW'(-StepsW'(sty)) : StepsW'(sty);
      m_tdata[38]      <= negx;
      m_tdata[39]      <= negy;
      m_tdata[58:40]   <= dist_ln[DistLn-1];
      m_tdata[97:59]   <= dur_ln[DivLat-1];
      m_tdata[136:98]  <= (stx == '0) ? '0 : px;
      m_tdata[175:137] <= (sty == '0) ? '0 : py;
    end
  end

endmodule

@@ hdl/psp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module psp_div
  import psp_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic [DivW-1:0]     dividend,
  input  logic [DivisorW-1:0] divisor,
  output logic [DivW-1:0]     quotient
);

  logic [DivisorW-1:0] rem [0:DivLat-1];
  logic [DivW-1:0]     work [0:DivLat-1];
  logic [DivisorW-1:0] dv [0:DivLat-1];

  for (genvar i = 0; i < DivLat; i++) begin : g_stage
    logic [DivisorW-1:0] rem_in;
    logic [DivW-1:0]     work_in;
    logic [DivisorW-1:0] dv_in;
    logic [DivisorW:0]   trial;
    logic                ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = dividend;
      assign dv_in   = divisor;
    end else begin : g_next
      assign rem_in  = rem[i-1];
      assign work_in = work[i-1];
      assign dv_in   = dv[i-1];
    end

    assign trial = {rem_in, work_in[DivW-1]};
    assign ge    = trial >= {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= ge ? DivisorW'(trial - {1'b0, dv_in}) : trial[DivisorW-1:0];
        work[i] <= {work_in[DivW-2:0], ge};
        dv[i]   <= dv_in;
      end
    end
  end

  assign quotient = work[DivLat-1];

endmodule

@@ hdl/psp_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module psp_sqrt
  import psp_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [SqInW-1:0] radicand,
  output logic [DistW-1:0] root
);

  localparam int TW = SqRemW + 2;

  logic [SqRemW-1:0] rem [0:SqLat-1];
  logic [DistW-1:0]  res [0:SqLat-1];
  logic [SqInW-1:0]  val [0:SqLat-1];

  for (genvar i = 0; i < SqLat; i++) begin : g_stage
    logic [SqRemW-1:0] rem_in;
    logic [DistW-1:0]  res_in;
    logic [SqInW-1:0]  val_in;
    logic [TW-1:0]     acc;
    logic [TW-1:0]     trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign res_in = '0;
      assign val_in = radicand;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign res_in = res[i-1];
      assign val_in = val[i-1];
    end

    assign acc   = {rem_in, val_in[SqInW-1 -: 2]};
    assign trial = TW'({res_in, 2'b01});
    assign ge    = acc >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? SqRemW'(acc - trial) : acc[SqRemW-1:0];
        res[i] <= {res_in[DistW-2:0], ge};
        val[i] <= {val_in[SqInW-3:0], 2'b00};
      end
    end
  end

  assign root = res[SqLat-1];

endmodule

@@ test/plotter_segment_step_planner_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plotter_segment_step_planner_checker
// Watches the segment and plan channels and the register port, predicts each
// plan from the accepted segment and the live register values, and compares
// the plans in order, field by field.
// ----------------------------------------------------------------------------
module plotter_segment_step_planner_checker
  import psp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [71:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [175:0] m_tdata,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic [TimeW-1:0]  period_y;
    logic [TimeW-1:0]  period_x;
    logic [TimeW-1:0]  duration;
    logic [DistW-1:0]  distance;
    logic              dir_y;
    logic              dir_x;
    logic [StepsW-1:0] steps_y;
    logic [StepsW-1:0] steps_x;
  } plan_t;

  plan_t plan_q[$];
  logic [CfgW-1:0] speed_reg;
  logic [CfgW-1:0] step_reg;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] rem;
    logic [63:0] trial;
    root = 0;
    rem = 0;
    for (int i = 31; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 64'd1;
      end
    end
    return root;
  endfunction

  function automatic plan_t plan_segment(input logic [71:0] seg);
    logic [63:0] sx, sy, ex, ey, ax, ay, stx, sty, dist_um, dur, spd, slen;
    logic nx, ny;
    plan_t p;
    sx = seg[17:0];
    sy = seg[35:18];
    ex = seg[53:36];
    ey = seg[71:54];
    spd = (speed_reg == 0) ? 64'd1 : 64'(speed_reg);
    slen = (step_reg == 0) ? 64'd1 : 64'(step_reg);
    nx = ex < sx;
    ny = ey < sy;
    ax = nx ? sx - ex : ex - sx;
    ay = ny ? sy - ey : ey - sy;
    stx = ax / slen;
    sty = ay / slen;
    dist_um = int_sqrt(ax * ax + ay * ay);
    dur = dist_um * 64'd1000000 / spd;
    p.dir_x = nx && stx != 0;
    p.dir_y = ny && sty != 0;
    p.steps_x = p.dir_x ? StepsW'(-stx) : StepsW'(stx);
    p.steps_y = p.dir_y ? StepsW'(-sty) : StepsW'(sty);
    p.distance = DistW'(dist_um);
    p.duration = TimeW'(dur);
    p.period_x = (stx != 0) ? TimeW'(dur / stx) : '0;
    p.period_y = (sty != 0) ? TimeW'(dur / sty) : '0;
    return p;
  endfunction

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  initial errors = 0;
  initial pending = 0;

  always @(posedge clk) begin
    plan_t got;
    plan_t want;
    if (rst) begin
      speed_reg <= SpeedReset;
      step_reg <= StepReset;
      plan_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (plan_q.size() == 0) begin
          report("unexpected plan transaction", 64'd1, 64'd0);
        end else begin
          want = plan_q.pop_front();
          if (got.steps_x !== want.steps_x) report("steps_x", got.steps_x, want.steps_x);
          if (got.steps_y !== want.steps_y) report("steps_y", got.steps_y, want.steps_y);
          if (got.dir_x !== want.dir_x) report("dir_x", got.dir_x, want.dir_x);
          if (got.dir_y !== want.dir_y) report("dir_y", got.dir_y, want.dir_y);
          if (got.distance !== want.distance)
            report("distance_um", got.distance, want.distance);
          if (got.duration !== want.duration)
            report("duration_us", got.duration, want.duration);
          if (got.period_x !== want.period_x)
            report("period_x_us", got.period_x, want.period_x);
          if (got.period_y !== want.period_y)
            report("period_y_us", got.period_y, want.period_y);
        end
      end
      if (s_tvalid && s_tready) plan_q.push_back(plan_segment(s_tdata));
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SPEED) speed_reg <= pwdata[CfgW-1:0];
        else step_reg <= pwdata[CfgW-1:0];
      end
    end
    pending = plan_q.size();
  end

endmodule

@@ test/plotter_segment_step_planner_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plotter_segment_step_planner_tb
// Drives segments through the planner under several speed and step length
// settings, with random gaps and stalls, and gives the verdict from the
// checker's mismatch count.
// ----------------------------------------------------------------------------
module plotter_segment_step_planner_tb;
  import psp_pkg::*;

  localparam int Latency = 102;

  logic         clk;
  logic         rst;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid;
  logic         s_tready;
  logic [71:0]  s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [175:0] m_tdata;
  int           errors;
  int           pending;
  bit           calm;
  bit           sink_on;

  plotter_segment_step_planner uut (.*);

  plotter_segment_step_planner_checker chk (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #300ms;
    $display("TEST FAILED");
    $finish;
  end

  // random stall bursts on the plan side
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (1) begin
      if (!calm && sink_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (Latency + 10) @(negedge clk);
  endtask

  task automatic send(input logic [17:0] sx, input logic [17:0] sy,
                      input logic [17:0] ex, input logic [17:0] ey);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ey, ex, sy, sx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [17:0] rnd_coord();
    case ($urandom_range(0, 7))
      0: return 18'($urandom);
      1: return 18'($urandom_range(0, 20));
      2: return 18'h3FFFF - 18'($urandom_range(0, 20));
      default: return 18'($urandom_range(0, 200000));
    endcase
  endfunction

  task automatic random_phase(input int n);
    logic [17:0] sx, sy;
    for (int i = 0; i < n; i++) begin
      sx = rnd_coord();
      sy = rnd_coord();
      if ($urandom_range(0, 4) == 0)
        send(sx, sy, sx + 18'($urandom_range(0, 400)), sy - 18'($urandom_range(0, 400)));
      else
        send(sx, sy, rnd_coord(), rnd_coord());
    end
    s_tvalid <= 1'b0;
  endtask

  logic [15:0] speeds[6] = '{16'd100, 16'd1, 16'd65535, 16'd0, 16'd3000, 16'd777};
  logic [15:0] steps[6]  = '{16'd157, 16'd65535, 16'd1, 16'd0, 16'd10, 16'd4321};

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    sink_on = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    sink_on = 1'b1;
    @(negedge clk);

    send(18'd0, 18'd0, 18'd0, 18'd0);
    send(18'd0, 18'd0, 18'd200000, 18'd200000);
    send(18'd200000, 18'd200000, 18'd0, 18'd0);
    send(18'd0, 18'd0, 18'h3FFFF, 18'h3FFFF);
    send(18'h3FFFF, 18'h3FFFF, 18'd0, 18'd0);
    send(18'h3FFFF, 18'd0, 18'd0, 18'h3FFFF);
    send(18'd1000, 18'd1000, 18'd1100, 18'd1000);
    send(18'd1000, 18'd1000, 18'd1000, 18'd900);
    send(18'd500, 18'd500, 18'd400, 18'd650);
    send(18'd0, 18'd0, 18'd156, 18'd0);
    send(18'd156, 18'd0, 18'd0, 18'd157);
    send(18'd0, 18'd0, 18'd3, 18'd4);
    send(18'h2AAAA, 18'h15555, 18'h15555, 18'h2AAAA);
    s_tvalid <= 1'b0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_SPEED, speeds[ph]);
      write_reg(REG_STEP, steps[ph]);
      if (ph == 5) calm = 1'b1;
      random_phase(265);
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
